FILE: sv/fmcp_pkg.sv
// Package for the framed motor command parser.
// Holds the shared types, register indexes and reset constants.
// No dependencies.
package fmcp_pkg;

  // Default depth of the frame text, terminator included.
  localparam int BUFFER_CHARS_DEFAULT = 32;

  // Configuration port geometry and register indexes.
  localparam int CFG_INDEX_W = 8;
  localparam logic [CFG_INDEX_W-1:0] CFG_START_MARKER    = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_END_MARKER      = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_TOKEN_SEPARATOR = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_LEFT_CODE       = 8'd3;

  // Register reset values: '<', '>', 'Y', 'L'.
  localparam logic [7:0] START_MARKER_RST    = 8'd60;
  localparam logic [7:0] END_MARKER_RST      = 8'd62;
  localparam logic [7:0] TOKEN_SEPARATOR_RST = 8'd89;
  localparam logic [7:0] LEFT_CODE_RST       = 8'd76;

  // Character codes used by the value parser.
  localparam logic [7:0] CHAR_NUL   = 8'd0;
  localparam logic [7:0] CHAR_PLUS  = 8'd43;
  localparam logic [7:0] CHAR_MINUS = 8'd45;

  // Parse phase of the frame body, one-hot.
  typedef enum logic [6:0] {
    PH_LEAD    = 7'b0000001,
    PH_SECOND  = 7'b0000010,
    PH_SPACE   = 7'b0000100,
    PH_SIGN    = 7'b0001000,
    PH_DIGITS  = 7'b0010000,
    PH_ENDED   = 7'b0100000,
    PH_NOTOKEN = 7'b1000000
  } phase_t;

  typedef struct packed {
    logic [7:0] start_marker;
    logic [7:0] end_marker;
    logic [7:0] token_separator;
    logic [7:0] left_code;
  } cfg_t;

  typedef struct packed {
    phase_t     phase;
    logic       side_right;
    logic       value_negative;
    logic [7:0] value_magnitude;
  } parse_state_t;

  typedef struct packed {
    logic       side;
    logic [7:0] forward_duty;
    logic [7:0] reverse_duty;
  } result_t;

endpackage

FILE: sv/fmcp_body_step.sv
// Next-state logic for one body byte of a frame.
// Depends on fmcp_pkg for the parse state and configuration types.
// Purely combinational; the caller owns the state registers.
module fmcp_body_step (
  input  logic [7:0]            rx_byte,
  input  fmcp_pkg::cfg_t        cfg,
  input  fmcp_pkg::parse_state_t cur,
  output fmcp_pkg::parse_state_t nxt
);

  logic        is_sep;
  logic        stop;
  logic        is_space;
  logic        is_digit;
  logic [11:0] acc;
  logic [7:0]  acc_sat;

  always_comb begin
    is_sep   = (rx_byte == cfg.token_separator);
    stop     = (rx_byte == fmcp_pkg::CHAR_NUL) || is_sep;
    is_space = rx_byte inside {8'd32, [8'd9:8'd13]};
    is_digit = rx_byte inside {[8'd48:8'd57]};
    // Magnitude times ten plus the digit, saturated at 255.
    acc      = ({4'b0, cur.value_magnitude} << 3) + ({4'b0, cur.value_magnitude} << 1)
             + {8'b0, rx_byte[3:0]};
    acc_sat  = (acc > 12'd255) ? 8'hFF : acc[7:0];
  end

  always_comb begin
    nxt = cur;
    case (cur.phase)
      fmcp_pkg::PH_LEAD: begin
        if (rx_byte == fmcp_pkg::CHAR_NUL) begin
          nxt.phase = fmcp_pkg::PH_NOTOKEN;
        end else if (!is_sep) begin
          nxt.side_right = (rx_byte != cfg.left_code);
          nxt.phase      = fmcp_pkg::PH_SECOND;
        end
      end
      fmcp_pkg::PH_SECOND: begin
        nxt.phase = stop ? fmcp_pkg::PH_ENDED : fmcp_pkg::PH_SPACE;
      end
      fmcp_pkg::PH_SPACE: begin
        if (stop) begin
          nxt.phase = fmcp_pkg::PH_ENDED;
        end else if (is_space) begin
          nxt.phase = fmcp_pkg::PH_SPACE;
        end else if (rx_byte == fmcp_pkg::CHAR_PLUS) begin
          nxt.phase = fmcp_pkg::PH_SIGN;
        end else if (rx_byte == fmcp_pkg::CHAR_MINUS) begin
          nxt.value_negative = 1'b1;
          nxt.phase          = fmcp_pkg::PH_SIGN;
        end else if (is_digit) begin
          nxt.value_magnitude = acc_sat;
          nxt.phase           = fmcp_pkg::PH_DIGITS;
        end else begin
          nxt.phase = fmcp_pkg::PH_ENDED;
        end
      end
      fmcp_pkg::PH_SIGN, fmcp_pkg::PH_DIGITS: begin
        if (!stop && is_digit) begin
          nxt.value_magnitude = acc_sat;
          nxt.phase           = fmcp_pkg::PH_DIGITS;
        end else begin
          nxt.phase = fmcp_pkg::PH_ENDED;
        end
      end
      default: begin
        nxt = cur;
      end
    endcase
  end

endmodule

FILE: sv/framed_motor_command_parser_unit.sv
// A result is registered from its accepted end marker beat, into the output or skid register.
// Throughput: one byte per cycle; input stalls only while output and skid registers are full.
// The rate is set by the combinational body step (one multiply-by-ten add and saturate).
// Reset (rst_n low, synchronous): configuration returns to '<' '>' 'Y' 'L',
// the parser leaves any frame, and no result is pending.
// Depends on fmcp_pkg and fmcp_body_step.
module framed_motor_command_parser_unit #(
  parameter int BUFFER_CHARS = fmcp_pkg::BUFFER_CHARS_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // Input byte channel.
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [7:0]                       in_rx_byte,
  // Result channel.
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_side,
  output logic [7:0]                       out_forward_duty,
  output logic [7:0]                       out_reverse_duty,
  // Configuration write channel.
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [fmcp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [7:0]                       cfg_data
);

  // The position counter only has to reach BUFFER_CHARS-1, the number of
  // body bytes that are kept.
  localparam int POS_W = $clog2(BUFFER_CHARS);
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(BUFFER_CHARS - 1);

  fmcp_pkg::cfg_t         cfg_r;
  logic                   in_frame_r;
  logic [POS_W-1:0]       pos_r;
  fmcp_pkg::parse_state_t st_r;
  fmcp_pkg::parse_state_t st_step;

  logic                   out_valid_r;
  logic                   skid_valid_r;
  fmcp_pkg::result_t      out_data_r;
  fmcp_pkg::result_t      skid_data_r;

  logic                   in_fire;
  logic                   out_fire;
  logic                   is_start;
  logic                   is_end;
  logic                   res_valid;
  fmcp_pkg::result_t      res;
  fmcp_pkg::parse_state_t st_clear;

  // Configuration writes are always taken; unknown indexes are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_marker    <= fmcp_pkg::START_MARKER_RST;
      cfg_r.end_marker      <= fmcp_pkg::END_MARKER_RST;
      cfg_r.token_separator <= fmcp_pkg::TOKEN_SEPARATOR_RST;
      cfg_r.left_code       <= fmcp_pkg::LEFT_CODE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        fmcp_pkg::CFG_START_MARKER:    cfg_r.start_marker    <= cfg_data;
        fmcp_pkg::CFG_END_MARKER:      cfg_r.end_marker      <= cfg_data;
        fmcp_pkg::CFG_TOKEN_SEPARATOR: cfg_r.token_separator <= cfg_data;
        fmcp_pkg::CFG_LEFT_CODE:       cfg_r.left_code       <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // The skid register is the only thing that can hold off the input: while it
  // is empty a new result always has somewhere to go.
  assign in_stall = skid_valid_r;
  assign in_fire  = in_valid && !in_stall;
  assign out_fire = out_valid_r && !out_stall;

  assign is_start = (in_rx_byte == cfg_r.start_marker);
  assign is_end   = (in_rx_byte == cfg_r.end_marker);

  // A frame yields a result only when its token reached at least one byte.
  assign res_valid = in_fire && in_frame_r && is_end
                   && (st_r.phase != fmcp_pkg::PH_LEAD)
                   && (st_r.phase != fmcp_pkg::PH_NOTOKEN);

  always_comb begin
    res.side         = st_r.side_right;
    res.forward_duty = st_r.value_negative ? 8'd0 : st_r.value_magnitude;
    res.reverse_duty = st_r.value_negative ? st_r.value_magnitude : 8'd0;

    st_clear.phase           = fmcp_pkg::PH_LEAD;
    st_clear.side_right      = 1'b0;
    st_clear.value_negative  = 1'b0;
    st_clear.value_magnitude = 8'd0;
  end

  fmcp_body_step u_body_step (
    .rx_byte (in_rx_byte),
    .cfg     (cfg_r),
    .cur     (st_r),
    .nxt     (st_step)
  );

  // Frame tracking. Outside a frame only the start marker matters; inside, the
  // end marker closes the frame and every other byte is a body byte as long as
  // the kept text is not yet full.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      pos_r      <= '0;
      st_r       <= st_clear;
    end else if (in_fire) begin
      if (!in_frame_r) begin
        if (is_start) begin
          in_frame_r <= 1'b1;
          pos_r      <= '0;
          st_r       <= st_clear;
        end
      end else if (is_end) begin
        in_frame_r <= 1'b0;
        pos_r      <= '0;
        st_r       <= st_clear;
      end else if (pos_r < POS_LAST) begin
        pos_r <= pos_r + POS_W'(1);
        st_r  <= st_step;
      end
    end
  end

  // Output register with one skid entry behind it. A result goes straight to
  // the output register when it is free or being taken this cycle; otherwise
  // it parks in the skid register and the input stalls until it drains.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_fire) begin
        skid_valid_r <= 1'b0;
      end
    end else if (res_valid) begin
      if (!out_valid_r || out_fire) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_fire) begin
        out_data_r <= skid_data_r;
      end
    end else if (res_valid) begin
      if (!out_valid_r || out_fire) begin
        out_data_r <= res;
      end else begin
        skid_data_r <= res;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_side         = out_data_r.side;
  assign out_forward_duty = out_data_r.forward_duty;
  assign out_reverse_duty = out_data_r.reverse_duty;

  // The skid entry is only ever filled behind a full output register.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register holds a beat while the output register is empty");

  // A new result follows an accepted end marker beat.
  a_result_from_end: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(in_fire && in_frame_r && is_end))
    else $error("result appeared without an end marker beat");

  // An accepted end marker always closes the frame.
  a_end_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_frame_r && is_end) |=> !in_frame_r)
    else $error("frame still open after its end marker");

  // The kept text never grows past its limit.
  a_pos_limit: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_LAST)
    else $error("character position beyond the kept text");

endmodule
